// ===== rtl/flip_and_nearest_scale_image_defines.svh =====
// ---------------------------------------------------------------------------
// flip_and_nearest_scale_image assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef FLIP_AND_NEAREST_SCALE_IMAGE_DEFINES_SVH
`define FLIP_AND_NEAREST_SCALE_IMAGE_DEFINES_SVH
`ifndef SYNTHESIS
`define FNSI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FNSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FNSI_ASSERT_NOW(lbl, ante, cons, msg)
`define FNSI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/fnsi_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnsi_pkg
// Sizes, register indexes, control structs and helpers of the image scaler.
// ---------------------------------------------------------------------------
package fnsi_pkg;

	localparam int MAX_SIDE      = 256;
	localparam int MAX_DEST_SIDE = 4096;

	localparam int BYTE_W     = 8;
	localparam int SRC_SIZE_W = 9;
	localparam int DST_SIZE_W = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam int SIDE_W = $clog2(MAX_SIDE);
	localparam int DEST_W = $clog2(MAX_DEST_SIDE);
	localparam int POS_W  = SIDE_W + 1;
	localparam int DEN_W  = DEST_W + 1;
	localparam int NUM_W  = ((DEST_W > POS_W) ? DEST_W : POS_W) + 1;
	localparam int CNT_W  = $clog2(NUM_W + 1);
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int WORD_W = 4 * BYTE_W;

	localparam logic [SRC_SIZE_W-1:0] SRC_SIZE_RESET = SRC_SIZE_W'(256);
	localparam logic [DST_SIZE_W-1:0] DST_SIZE_RESET = DST_SIZE_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH     = 3'd0,
		CFG_SRC_HEIGHT    = 3'd1,
		CFG_DST_WIDTH     = 3'd2,
		CFG_DST_HEIGHT    = 3'd3,
		CFG_SRC_HAS_ALPHA = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_FETCH = 1'b1
	} kind_t;

	typedef struct packed {
		logic load_wr;
		logic fetch;
		logic div_step;
		logic div_commit;
		logic out_push;
	} fnsi_cmd_t;

	typedef struct packed {
		logic wrap;
		logic div_last;
		logic out_free;
	} fnsi_stat_t;

	function automatic logic [POS_W-1:0] clamp_src(input logic [SRC_SIZE_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v == '0) begin
			r = POS_W'(1);
		end else if (v > SRC_SIZE_W'(MAX_SIDE)) begin
			r = POS_W'(MAX_SIDE);
		end else begin
			r = POS_W'(v);
		end
		return r;
	endfunction

	function automatic logic [DEN_W-1:0] clamp_dst(input logic [DST_SIZE_W-1:0] v);
		logic [DEN_W-1:0] r;
		if (v == '0) begin
			r = DEN_W'(1);
		end else if (v > DST_SIZE_W'(MAX_DEST_SIDE)) begin
			r = DEN_W'(MAX_DEST_SIDE);
		end else begin
			r = DEN_W'(v);
		end
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] sat_index(input logic [POS_W-1:0] pos,
			input logic [POS_W-1:0] size);
		logic [POS_W-1:0] sel;
		sel = (pos >= size) ? (size - POS_W'(1)) : pos;
		return sel[SIDE_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] pos,
			input logic [NUM_W-1:0] q);
		logic [NUM_W:0] sum;
		logic [POS_W-1:0] r;
		sum = (NUM_W+1)'(pos) + (NUM_W+1)'(q);
		if (sum >= (NUM_W+1)'(MAX_SIDE)) begin
			r = POS_W'(MAX_SIDE);
		end else begin
			r = sum[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/fnsi_stream_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnsi stream interfaces
// Valid/ready channels for input items and for result pixels.
// ---------------------------------------------------------------------------
interface fnsi_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [fnsi_pkg::BYTE_W-1:0] in_byte0;
	logic [fnsi_pkg::BYTE_W-1:0] in_byte1;
	logic [fnsi_pkg::BYTE_W-1:0] in_byte2;
	logic [fnsi_pkg::BYTE_W-1:0] in_byte3;

	modport source (output valid, kind, in_byte0, in_byte1, in_byte2, in_byte3,
		input ready);
	modport sink (input valid, kind, in_byte0, in_byte1, in_byte2, in_byte3,
		output ready);
endinterface

interface fnsi_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [fnsi_pkg::BYTE_W-1:0] out_byte0;
	logic [fnsi_pkg::BYTE_W-1:0] out_byte1;
	logic [fnsi_pkg::BYTE_W-1:0] out_byte2;
	logic [fnsi_pkg::BYTE_W-1:0] out_byte3;
	logic                        last_of_image;

	modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3,
		last_of_image, input ready);
	modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3,
		last_of_image, output ready);
endinterface

// ===== rtl/fnsi_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnsi_ctrl
// Sequencer: accepts items, runs the shared divider, commits and emits.
// ---------------------------------------------------------------------------
module fnsi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_kind,
	input  fnsi_pkg::fnsi_stat_t stat,
	output logic                 in_ready,
	output fnsi_pkg::fnsi_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_kind == fnsi_pkg::KIND_FETCH) begin
						cmd.fetch = 1'b1;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_DIVIDE: cmd.div_step   = 1'b1;
			ST_COMMIT: cmd.div_commit = 1'b1;
			ST_EMIT:   cmd.out_push   = stat.out_free;
			default:   cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && (in_kind == fnsi_pkg::KIND_FETCH)) begin
						state_q <= stat.wrap ? ST_EMIT : ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (stat.div_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/fnsi_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fnsi_datapath
// Configuration, frame store, position counters, DDA divider, output register.
// ---------------------------------------------------------------------------
module fnsi_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_en,
	input  logic [fnsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fnsi_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [fnsi_pkg::BYTE_W-1:0]       in_byte0,
	input  logic [fnsi_pkg::BYTE_W-1:0]       in_byte1,
	input  logic [fnsi_pkg::BYTE_W-1:0]       in_byte2,
	input  logic [fnsi_pkg::BYTE_W-1:0]       in_byte3,
	input  fnsi_pkg::fnsi_cmd_t               cmd,
	output fnsi_pkg::fnsi_stat_t              stat,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [fnsi_pkg::BYTE_W-1:0]       out_byte0,
	output logic [fnsi_pkg::BYTE_W-1:0]       out_byte1,
	output logic [fnsi_pkg::BYTE_W-1:0]       out_byte2,
	output logic [fnsi_pkg::BYTE_W-1:0]       out_byte3,
	output logic                              last_of_image
);

	localparam int SIDE_W = fnsi_pkg::SIDE_W;
	localparam int DEST_W = fnsi_pkg::DEST_W;
	localparam int POS_W  = fnsi_pkg::POS_W;
	localparam int DEN_W  = fnsi_pkg::DEN_W;
	localparam int NUM_W  = fnsi_pkg::NUM_W;
	localparam int CNT_W  = fnsi_pkg::CNT_W;
	localparam int BYTE_W = fnsi_pkg::BYTE_W;
	localparam int WORD_W = fnsi_pkg::WORD_W;
	localparam int DEPTH  = fnsi_pkg::MAX_SIDE * fnsi_pkg::MAX_SIDE;

	logic [fnsi_pkg::SRC_SIZE_W-1:0] src_width_q, src_height_q;
	logic [fnsi_pkg::DST_SIZE_W-1:0] dst_width_q, dst_height_q;
	logic                            src_has_alpha_q;

	logic [SIDE_W-1:0] load_col_q, load_row_q;
	logic [DEST_W-1:0] out_col_q, out_row_q;
	logic [POS_W-1:0]  src_col_q, src_row_q;
	logic [DEST_W-1:0] col_rem_q, row_rem_q;

	logic [NUM_W-1:0] div_n_q;
	logic [DEN_W-1:0] div_r_q, div_d_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             axis_q;
	logic             last_q;

	logic [WORD_W-1:0] store_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic              out_valid_q;

	logic [POS_W-1:0]  sw, sh;
	logic [DEN_W-1:0]  dw, dh;
	logic              col_end, row_end, load_col_end, load_row_end;
	logic [SIDE_W-1:0] wr_col, wr_row, rd_col, rd_row;
	logic [POS_W-1:0]  sh_m1;
	logic [WORD_W-1:0] wr_word;
	logic [NUM_W-1:0]  fetch_num;
	logic [DEN_W:0]    trial, trial_sub;
	logic              trial_ge;
	logic [DEN_W-1:0]  next_r;

	assign sw = fnsi_pkg::clamp_src(src_width_q);
	assign sh = fnsi_pkg::clamp_src(src_height_q);
	assign dw = fnsi_pkg::clamp_dst(dst_width_q);
	assign dh = fnsi_pkg::clamp_dst(dst_height_q);

	assign col_end      = (DEN_W'(out_col_q) + DEN_W'(1)) >= dw;
	assign row_end      = (DEN_W'(out_row_q) + DEN_W'(1)) >= dh;
	assign load_col_end = (POS_W'(load_col_q) + POS_W'(1)) >= sw;
	assign load_row_end = (POS_W'(load_row_q) + POS_W'(1)) >= sh;

	assign sh_m1   = sh - POS_W'(1);
	assign wr_col  = fnsi_pkg::sat_index(POS_W'(load_col_q), sw);
	assign wr_row  = sh_m1[SIDE_W-1:0] - fnsi_pkg::sat_index(POS_W'(load_row_q), sh);
	assign rd_col  = fnsi_pkg::sat_index(src_col_q, sw);
	assign rd_row  = fnsi_pkg::sat_index(src_row_q, sh);
	assign wr_word = {(src_has_alpha_q ? in_byte3 : BYTE_W'(0)), in_byte2, in_byte1, in_byte0};

	assign fetch_num = col_end ? (NUM_W'(row_rem_q) + NUM_W'(sh))
		: (NUM_W'(col_rem_q) + NUM_W'(sw));

	assign trial     = {div_r_q, div_n_q[NUM_W-1]};
	assign trial_ge  = trial >= {1'b0, div_d_q};
	assign trial_sub = trial - {1'b0, div_d_q};
	assign next_r    = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

	assign stat.wrap     = col_end && row_end;
	assign stat.div_last = (div_cnt_q == CNT_W'(1));
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= fnsi_pkg::SRC_SIZE_RESET;
			src_height_q    <= fnsi_pkg::SRC_SIZE_RESET;
			dst_width_q     <= fnsi_pkg::DST_SIZE_RESET;
			dst_height_q    <= fnsi_pkg::DST_SIZE_RESET;
			src_has_alpha_q <= 1'b1;
		end else if (cfg_en) begin
			unique case (cfg_index)
				fnsi_pkg::CFG_SRC_WIDTH:     src_width_q  <= cfg_data[fnsi_pkg::SRC_SIZE_W-1:0];
				fnsi_pkg::CFG_SRC_HEIGHT:    src_height_q <= cfg_data[fnsi_pkg::SRC_SIZE_W-1:0];
				fnsi_pkg::CFG_DST_WIDTH:     dst_width_q  <= cfg_data[fnsi_pkg::DST_SIZE_W-1:0];
				fnsi_pkg::CFG_DST_HEIGHT:    dst_height_q <= cfg_data[fnsi_pkg::DST_SIZE_W-1:0];
				fnsi_pkg::CFG_SRC_HAS_ALPHA: src_has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q <= '0;
			load_row_q <= '0;
		end else if (cmd.load_wr) begin
			if (load_col_end) begin
				load_col_q <= '0;
				load_row_q <= load_row_end ? '0 : (load_row_q + SIDE_W'(1));
			end else begin
				load_col_q <= load_col_q + SIDE_W'(1);
			end
		end
	end

	// step the output position at accept, the source position at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_col_q <= '0;
			out_row_q <= '0;
			src_col_q <= '0;
			src_row_q <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
		end else if (cmd.fetch) begin
			if (!col_end) begin
				out_col_q <= out_col_q + DEST_W'(1);
			end else begin
				out_col_q <= '0;
				src_col_q <= '0;
				col_rem_q <= '0;
				if (!row_end) begin
					out_row_q <= out_row_q + DEST_W'(1);
				end else begin
					out_row_q <= '0;
					src_row_q <= '0;
					row_rem_q <= '0;
				end
			end
		end else if (cmd.div_commit) begin
			if (axis_q) begin
				src_row_q <= fnsi_pkg::sat_add(src_row_q, div_n_q);
				row_rem_q <= div_r_q[DEST_W-1:0];
			end else begin
				src_col_q <= fnsi_pkg::sat_add(src_col_q, div_n_q);
				col_rem_q <= div_r_q[DEST_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.fetch) begin
			div_cnt_q <= CNT_W'(NUM_W);
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
	end

	// restoring divide, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			div_n_q <= fetch_num;
			div_r_q <= '0;
			div_d_q <= col_end ? dh : dw;
			axis_q  <= col_end;
			last_q  <= col_end && row_end;
		end else if (cmd.div_step) begin
			div_n_q <= {div_n_q[NUM_W-2:0], trial_ge};
			div_r_q <= next_r;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			store_q[{wr_row, wr_col}] <= wr_word;
		end
		if (cmd.fetch) begin
			rdata_q <= store_q[{rd_row, rd_col}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_push) begin
			out_byte0     <= rdata_q[BYTE_W-1:0];
			out_byte1     <= rdata_q[2*BYTE_W-1:BYTE_W];
			out_byte2     <= rdata_q[3*BYTE_W-1:2*BYTE_W];
			out_byte3     <= rdata_q[4*BYTE_W-1:3*BYTE_W];
			last_of_image <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/flip_and_nearest_scale_image.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flip_and_nearest_scale_image
// Row-flipping frame store loader with nearest-neighbor scaled read-out.
// ---------------------------------------------------------------------------
//  channel   dir   beat contents
//  req       in    kind, in_byte0..in_byte3 (load or fetch)
//  rsp       out   out_byte0..out_byte3, last_of_image (one per fetch)
//  cfg_*     in    register write: cfg_en, cfg_index, cfg_data
//
//  Loads stream back to back.
//  A fetch beat steps the DDA through a 13-step shared restoring divider,
//  then a commit state; on the last pixel of an image it skips both.
//  One frame store port serves the load write and the fetch read.
//  A full rsp register holds the next fetch result until the beat is taken.
//  Reset clears counters and control; the frame store is not cleared.
// ---------------------------------------------------------------------------
`include "flip_and_nearest_scale_image_defines.svh"

module flip_and_nearest_scale_image (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_en,
	input  logic [fnsi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fnsi_pkg::CFG_DATA_W-1:0] cfg_data,
	fnsi_req_if.sink                        req,
	fnsi_rsp_if.source                      rsp
);

	fnsi_pkg::fnsi_cmd_t  cmd;
	fnsi_pkg::fnsi_stat_t stat;

	fnsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.stat     (stat),
		.in_ready (req.ready),
		.cmd      (cmd)
	);

	fnsi_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_en        (cfg_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_byte0      (req.in_byte0),
		.in_byte1      (req.in_byte1),
		.in_byte2      (req.in_byte2),
		.in_byte3      (req.in_byte3),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_byte0     (rsp.out_byte0),
		.out_byte1     (rsp.out_byte1),
		.out_byte2     (rsp.out_byte2),
		.out_byte3     (rsp.out_byte3),
		.last_of_image (rsp.last_of_image)
	);

	`FNSI_ASSERT_NOW(a_push_into_free_slot, cmd.out_push, (!rsp.valid || rsp.ready), "push into a full output register")
	`FNSI_ASSERT_NEXT(a_fetch_blocks_input, (req.valid && req.ready && req.kind), !req.ready, "input taken during a fetch")
	`FNSI_ASSERT_NOW(a_result_from_push, $rose(rsp.valid), $past(cmd.out_push), "result shown without a push")

endmodule

// ===== test/flip_and_nearest_scale_image_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flip_and_nearest_scale_image_test
// Streams bottom-up source images into the scaler and reads back the resized
// picture. A local model of the frame store and both stepping counters
// predicts every output pixel; results are checked in order as they leave.
// Sizes sweep from one pixel up to the largest source and destination
// sides, including zero and oversized register values. Both handshake sides
// pause at random.
// ---------------------------------------------------------------------------
module flip_and_nearest_scale_image_test;

	localparam int BYTE_W        = fnsi_pkg::BYTE_W;
	localparam int WORD_W        = fnsi_pkg::WORD_W;
	localparam int MAX_SIDE      = fnsi_pkg::MAX_SIDE;
	localparam int MAX_DEST_SIDE = fnsi_pkg::MAX_DEST_SIDE;
	localparam int CFG_IDX_W     = fnsi_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W    = fnsi_pkg::CFG_DATA_W;
	localparam int SRC_SIZE_W    = fnsi_pkg::SRC_SIZE_W;
	localparam int DST_SIZE_W    = fnsi_pkg::DST_SIZE_W;

	localparam int TAIL_CYCLES = 40;
	localparam int MIX_BEATS   = 40;
	localparam int RAND_PHASES = 6;
	localparam int BIG_FETCHES = 48;
	localparam int FETCH_PCT   = 65;
	localparam int SHOW_ERRORS = 10;

	typedef struct packed {
		fnsi_pkg::kind_t   kind;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
	} pixel_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
		logic              last;
	} pixel_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fnsi_req_if req_ch ();
	fnsi_rsp_if rsp_ch ();

	flip_and_nearest_scale_image i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// register shadows, as written
	logic [SRC_SIZE_W-1:0] reg_src_w = fnsi_pkg::SRC_SIZE_RESET;
	logic [SRC_SIZE_W-1:0] reg_src_h = fnsi_pkg::SRC_SIZE_RESET;
	logic [DST_SIZE_W-1:0] reg_dst_w = fnsi_pkg::DST_SIZE_RESET;
	logic [DST_SIZE_W-1:0] reg_dst_h = fnsi_pkg::DST_SIZE_RESET;
	logic                  reg_alpha = 1'b1;

	// frame store model and scan positions
	logic [WORD_W-1:0] image_mem [MAX_SIDE*MAX_SIDE];
	int unsigned fill_x = 0;
	int unsigned fill_y = 0;
	int unsigned dest_x = 0;
	int unsigned dest_y = 0;
	int unsigned pick_x = 0;
	int unsigned acc_x = 0;
	int unsigned pick_y = 0;
	int unsigned acc_y = 0;

	pixel_req_t pending_beats [$];
	pixel_out_t expected_pixels [$];
	pixel_req_t next_beat;
	pixel_out_t want_px;
	pixel_out_t got_px;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats_queued = 0;
	int beats_taken = 0;
	int fail_count = 0;
	int loads_seen = 0;
	int fetches_seen = 0;
	int images_done = 0;
	int settings_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_size(input int unsigned raw, input int unsigned top);
		if (raw == 0)
			return 1;
		return (raw > top) ? top : raw;
	endfunction

	function automatic int unsigned clip_index(input int unsigned pos, input int unsigned size);
		return (pos >= size) ? size - 1 : pos;
	endfunction

	function automatic void apply_beat(input pixel_req_t it);
		int unsigned sw;
		int unsigned sh;
		int unsigned dw;
		int unsigned dh;
		int unsigned x;
		int unsigned y;
		logic [WORD_W-1:0] word;
		pixel_out_t px;
		logic col_end;
		logic row_end;
		sw = eff_size(reg_src_w, MAX_SIDE);
		sh = eff_size(reg_src_h, MAX_SIDE);
		dw = eff_size(reg_dst_w, MAX_DEST_SIDE);
		dh = eff_size(reg_dst_h, MAX_DEST_SIDE);
		if (it.kind == fnsi_pkg::KIND_LOAD) begin
			x = clip_index(fill_x, sw);
			y = sh - 1 - clip_index(fill_y, sh);
			word = {(reg_alpha ? it.b3 : {BYTE_W{1'b0}}), it.b2, it.b1, it.b0};
			image_mem[y * MAX_SIDE + x] = word;
			if (fill_x + 1 >= sw) begin
				fill_x = 0;
				fill_y = (fill_y + 1 >= sh) ? 0 : fill_y + 1;
			end else begin
				fill_x++;
			end
			loads_seen++;
		end else begin
			word = image_mem[clip_index(pick_y, sh) * MAX_SIDE + clip_index(pick_x, sw)];
			col_end = (dest_x + 1 >= dw);
			row_end = (dest_y + 1 >= dh);
			px.b0 = word[BYTE_W-1:0];
			px.b1 = word[2*BYTE_W-1:BYTE_W];
			px.b2 = word[3*BYTE_W-1:2*BYTE_W];
			px.b3 = word[4*BYTE_W-1:3*BYTE_W];
			px.last = col_end && row_end;
			expected_pixels.push_back(px);
			if (!col_end) begin
				dest_x++;
				acc_x += sw;
				pick_x += acc_x / dw;
				acc_x = acc_x % dw;
			end else begin
				dest_x = 0;
				pick_x = 0;
				acc_x = 0;
				if (!row_end) begin
					dest_y++;
					acc_y += sh;
					pick_y += acc_y / dh;
					acc_y = acc_y % dh;
				end else begin
					dest_y = 0;
					pick_y = 0;
					acc_y = 0;
					images_done++;
				end
			end
			fetches_seen++;
		end
	endfunction

	function automatic void note_error(input string msg);
		fail_count++;
		if (fail_count <= SHOW_ERRORS)
			$display("ERROR at %0t: %s", $time, msg);
	endfunction

	// driver: hold a beat until taken, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_beat = pending_beats.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= next_beat.kind;
				req_ch.in_byte0 <= next_beat.b0;
				req_ch.in_byte1 <= next_beat.b1;
				req_ch.in_byte2 <= next_beat.b2;
				req_ch.in_byte3 <= next_beat.b3;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			beats_taken++;
			apply_beat('{fnsi_pkg::kind_t'(req_ch.kind), req_ch.in_byte0, req_ch.in_byte1,
				req_ch.in_byte2, req_ch.in_byte3});
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_px = '{rsp_ch.out_byte0, rsp_ch.out_byte1, rsp_ch.out_byte2,
					rsp_ch.out_byte3, rsp_ch.last_of_image};
				if (expected_pixels.size() == 0) begin
					note_error($sformatf("unexpected pixel %h %h %h %h last %b", got_px.b0,
						got_px.b1, got_px.b2, got_px.b3, got_px.last));
				end else begin
					want_px = expected_pixels.pop_front();
					if (got_px !== want_px)
						note_error($sformatf(
							"expected %h %h %h %h last %b, got %h %h %h %h last %b",
							want_px.b0, want_px.b1, want_px.b2, want_px.b3, want_px.last,
							got_px.b0, got_px.b1, got_px.b2, got_px.b3, got_px.last));
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 24;
				recv_idle_pct = 73;
			end
			1: begin
				send_idle_pct = 73;
				recv_idle_pct = 24;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic write_reg(input fnsi_pkg::cfg_reg_t idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			fnsi_pkg::CFG_SRC_WIDTH: reg_src_w = data[SRC_SIZE_W-1:0];
			fnsi_pkg::CFG_SRC_HEIGHT: reg_src_h = data[SRC_SIZE_W-1:0];
			fnsi_pkg::CFG_DST_WIDTH: reg_dst_w = data[DST_SIZE_W-1:0];
			fnsi_pkg::CFG_DST_HEIGHT: reg_dst_h = data[DST_SIZE_W-1:0];
			fnsi_pkg::CFG_SRC_HAS_ALPHA: reg_alpha = data[0];
			default: ;
		endcase
	endtask

	task automatic configure(input int unsigned sw, input int unsigned sh,
			input int unsigned dw, input int unsigned dh, input bit alpha);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[SRC_SIZE_W-1:0] = SRC_SIZE_W'(sw);
		write_reg(fnsi_pkg::CFG_SRC_WIDTH, data);
		data = CFG_DATA_W'($urandom);
		data[SRC_SIZE_W-1:0] = SRC_SIZE_W'(sh);
		write_reg(fnsi_pkg::CFG_SRC_HEIGHT, data);
		write_reg(fnsi_pkg::CFG_DST_WIDTH, CFG_DATA_W'(dw));
		write_reg(fnsi_pkg::CFG_DST_HEIGHT, CFG_DATA_W'(dh));
		data = CFG_DATA_W'($urandom);
		data[0] = alpha;
		write_reg(fnsi_pkg::CFG_SRC_HAS_ALPHA, data);
		for (int k = int'(fnsi_pkg::CFG_SRC_HAS_ALPHA) + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(fnsi_pkg::cfg_reg_t'(k), CFG_DATA_W'($urandom));
		@(posedge clk);
		cfg_en <= 1'b0;
		settings_used++;
	endtask

	task automatic push_beat(input fnsi_pkg::kind_t k, input logic [BYTE_W-1:0] b0,
			input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
			input logic [BYTE_W-1:0] b3);
		pending_beats.push_back('{k, b0, b1, b2, b3});
		beats_queued++;
	endtask

	task automatic queue_random(input fnsi_pkg::kind_t k, input int n);
		for (int i = 0; i < n; i++)
			push_beat(k, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
				BYTE_W'($urandom));
	endtask

	// fill every store word of the current size, whatever the load position
	task automatic prime_image();
		int unsigned sw;
		int unsigned sh;
		int unsigned n;
		sw = eff_size(reg_src_w, MAX_SIDE);
		sh = eff_size(reg_src_h, MAX_SIDE);
		n = sw * sh;
		if (fill_x >= sw || fill_y >= sh)
			n += sw;
		queue_random(fnsi_pkg::KIND_LOAD, int'(n));
	endtask

	task automatic queue_mix(input int n);
		for (int i = 0; i < n; i++)
			queue_random(($urandom_range(99) < FETCH_PCT) ? fnsi_pkg::KIND_FETCH
				: fnsi_pkg::KIND_LOAD, 1);
	endtask

	task automatic drain();
		while (beats_taken != beats_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned sw;
		int unsigned sh;
		int unsigned dw;
		int unsigned dh;
		req_ch.valid = 1'b0;
		req_ch.kind = fnsi_pkg::KIND_LOAD;
		req_ch.in_byte0 = '0;
		req_ch.in_byte1 = '0;
		req_ch.in_byte2 = '0;
		req_ch.in_byte3 = '0;
		rsp_ch.ready = 1'b0;
		set_idling(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 source to 3x3, byte extremes, alpha kept
		configure(2, 2, 3, 3, 1'b1);
		push_beat(fnsi_pkg::KIND_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
		push_beat(fnsi_pkg::KIND_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_beat(fnsi_pkg::KIND_LOAD, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
		push_beat(fnsi_pkg::KIND_LOAD, 8'h81, 8'h42, 8'h24, 8'h18);
		queue_random(fnsi_pkg::KIND_FETCH, 9);
		drain();

		// zero sizes act as one pixel; 24 bpp drops alpha; fetch wraps
		configure(0, 0, 0, 0, 1'b0);
		push_beat(fnsi_pkg::KIND_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_random(fnsi_pkg::KIND_FETCH, 2);
		drain();

		// oversized widths saturate to the largest sides
		configure(511, 1, 8191, 1, 1'b1);
		prime_image();
		queue_random(fnsi_pkg::KIND_FETCH, BIG_FETCHES);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_idling(ph * 3 / RAND_PHASES);
			if (ph == RAND_PHASES / 2) begin
				configure(1, MAX_SIDE, 1, MAX_DEST_SIDE, 1'b0);
				prime_image();
				queue_random(fnsi_pkg::KIND_FETCH, BIG_FETCHES);
				drain();
			end
			sw = ($urandom_range(19) == 0) ? $urandom_range(257, 511) : $urandom_range(6);
			if (eff_size(sw, MAX_SIDE) <= 2 && $urandom_range(9) == 0)
				sh = $urandom_range(200, 511);
			else
				sh = $urandom_range(eff_size(sw, MAX_SIDE) > 8 ? 2 : 6);
			dw = ($urandom_range(7) == 0) ? $urandom_range(4097, 8191) : $urandom_range(12);
			dh = ($urandom_range(7) == 0) ? $urandom_range(4097, 8191) : $urandom_range(12);
			configure(sw, sh, dw, dh, $urandom_range(1));
			prime_image();
			if (ph == RAND_PHASES / 3) begin
				queue_mix(MIX_BEATS / 2);
				drain();
				queue_mix(MIX_BEATS / 2);
			end else begin
				queue_mix(MIX_BEATS);
			end
			drain();
		end

		set_idling(2);
		drain();
		if (expected_pixels.size() != 0)
			note_error($sformatf("%0d pixels never arrived", expected_pixels.size()));
		$display("Covered %0d loads and %0d fetched pixels (%0d full images) over %0d settings",
			loads_seen, fetches_seen, images_done, settings_used);
		$display("Mismatches: %0d", fail_count);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d pixels still awaited", expected_pixels.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
